FILE: hdl/pfa_pkg.sv
// Shared constants, types and helpers of the page frame allocator.
package pfa_pkg;

  localparam int NumPages = 4096;
  localparam int PageW    = 13;
  localparam int AddrW    = 24;
  localparam int OffsW    = 12;
  localparam int PageIdxW = AddrW - OffsW;
  localparam int ScanMax  = (NumPages < (1 << PageIdxW)) ? NumPages : (1 << PageIdxW);
  localparam int RowW     = 64;
  localparam int NumRows  = ScanMax / RowW;
  localparam int RowIdxW  = $clog2(NumRows);
  localparam int BitIdxW  = $clog2(RowW);
  localparam int CfgIdxW  = 2;

  localparam logic [PageW-1:0] ReservedReset = PageW'(256);
  localparam logic [PageW-1:0] TotalReset    = PageW'(4096);
  localparam logic [PageW-1:0] ScanMaxPages  = PageW'(ScanMax);
  localparam logic [PageW-1:0] FreeMax       = {PageW{1'b1}};

  localparam logic [CfgIdxW-1:0] REG_RESERVED = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_TOTAL    = CfgIdxW'(1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef struct packed {
    logic    capture;
    logic    rd;
    logic    step;
    logic    commit;
    logic    set_status;
    status_t status;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic    early;
    status_t early_status;
    logic    is_alloc;
    logic    hit;
    logic    last_row;
  } sts_t;

  // Scan end clamped to what the store and the address reach.
  function automatic logic [PageW-1:0] scan_end(input logic [PageW-1:0] total);
    scan_end = (total > ScanMaxPages) ? ScanMaxPages : total;
  endfunction

  function automatic logic [PageW-1:0] free_init(input logic [PageW-1:0] reserved,
                                                 input logic [PageW-1:0] total);
    logic [PageW-1:0] e;
    e = scan_end(total);
    free_init = (e > reserved) ? (e - reserved) : '0;
  endfunction

endpackage

FILE: hdl/pfa_if.sv
// Channel interfaces of the page frame allocator: request, result and configuration.
interface pfa_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [pfa_pkg::AddrW-1:0]       page_address;
  modport source (output valid, mode, page_address, input ready);
  modport sink   (input valid, mode, page_address, output ready);
endinterface

interface pfa_out_if;
  logic                            valid;
  logic                            ready;
  pfa_pkg::status_t                status;
  logic [pfa_pkg::AddrW-1:0]       granted_address;
  logic [pfa_pkg::PageW-1:0]       free_count;
  modport source (output valid, status, granted_address, free_count, input ready);
  modport sink   (input valid, status, granted_address, free_count, output ready);
endinterface

interface pfa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfa_pkg::CfgIdxW-1:0]     index;
  logic [pfa_pkg::PageW-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
  parameter int W = 64,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/pfa_ctrl.sv
// Controller state machine that sequences the row scan and the result beat.
module pfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pfa_pkg::sts_t sts,
  output pfa_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_CHECK = 5'b00100,
    S_DONE  = 5'b01000,
    S_SPARE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.status    = pfa_pkg::ST_OK;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (sts.early) begin
          cmd.set_status = 1'b1;
          cmd.status     = sts.early_status;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.hit) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end else if (!sts.is_alloc) begin
          cmd.set_status = 1'b1;
          cmd.status     = pfa_pkg::ST_NOT_USED;
          state_nxt      = S_DONE;
        end else if (sts.last_row) begin
          cmd.set_status = 1'b1;
          cmd.status     = pfa_pkg::ST_OOM;
          state_nxt      = S_DONE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_ISSUE;
        end
      end
      S_DONE: begin
        // The finished result moves to the output register once it is free.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/pfa_dp.sv
// Datapath: configuration registers, free counter, use-mark store and row scan logic.
module pfa_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfa_pkg::cmd_t                   cmd,
  output pfa_pkg::sts_t                   sts,
  input  logic                            in_mode,
  input  logic [pfa_pkg::AddrW-1:0]       in_page_address,
  input  logic                            cfg_we,
  input  logic [pfa_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [pfa_pkg::PageW-1:0]       cfg_data,
  output pfa_pkg::status_t                out_status,
  output logic [pfa_pkg::AddrW-1:0]       out_granted_address,
  output logic [pfa_pkg::PageW-1:0]       out_free_count
);

  logic [pfa_pkg::PageW-1:0]     reserved_r, reserved_nxt;
  logic [pfa_pkg::PageW-1:0]     total_r, total_nxt;
  logic [pfa_pkg::PageW-1:0]     free_r, free_nxt;
  logic [pfa_pkg::NumRows-1:0]   row_vld_r, row_vld_nxt;
  logic                          rd_vld_r;
  logic                          mode_r;
  logic [pfa_pkg::AddrW-1:0]     addr_r;
  logic [pfa_pkg::RowIdxW-1:0]   row_r;
  pfa_pkg::status_t              res_status_r;
  logic [pfa_pkg::AddrW-1:0]     res_grant_r;
  pfa_pkg::status_t              out_status_r;
  logic [pfa_pkg::AddrW-1:0]     out_grant_r;
  logic [pfa_pkg::PageW-1:0]     out_free_r;

  logic [pfa_pkg::PageW-1:0]     end_pg;
  logic [pfa_pkg::PageW-1:0]     last_pg;
  logic                          empty;
  logic [pfa_pkg::RowIdxW-1:0]   first_row;
  logic [pfa_pkg::RowIdxW-1:0]   last_row;
  logic [pfa_pkg::PageW-1:0]     rel_pg;
  logic                          rel_bad;
  logic [pfa_pkg::RowW-1:0]      ram_q;
  logic [pfa_pkg::RowW-1:0]      word;
  logic [pfa_pkg::RowW-1:0]      lo_mask;
  logic [pfa_pkg::RowW-1:0]      hi_mask;
  logic [pfa_pkg::RowW-1:0]      free_bits;
  logic [pfa_pkg::BitIdxW-1:0]   hi_shift;
  logic [pfa_pkg::BitIdxW-1:0]   pick;
  logic [pfa_pkg::BitIdxW-1:0]   rel_bit;
  logic [pfa_pkg::BitIdxW-1:0]   sel_bit;
  logic [pfa_pkg::RowW-1:0]      sel_onehot;
  logic [pfa_pkg::RowW-1:0]      wr_word;
  logic                          cfg_hit;

  // Scan bounds derived from the configuration.
  assign end_pg    = pfa_pkg::scan_end(total_r);
  assign last_pg   = end_pg - pfa_pkg::PageW'(1);
  assign empty     = reserved_r >= end_pg;
  assign first_row = reserved_r[pfa_pkg::PageIdxW-1:pfa_pkg::BitIdxW];
  assign last_row  = last_pg[pfa_pkg::PageIdxW-1:pfa_pkg::BitIdxW];

  assign rel_pg  = pfa_pkg::PageW'(addr_r[pfa_pkg::AddrW-1:pfa_pkg::OffsW]);
  assign rel_bad = (addr_r[pfa_pkg::OffsW-1:0] != '0) || (rel_pg < reserved_r) ||
                   (rel_pg >= end_pg);
  assign rel_bit = addr_r[pfa_pkg::OffsW+pfa_pkg::BitIdxW-1:pfa_pkg::OffsW];

  // A row that was never written since the last clear reads as all free.
  assign word     = rd_vld_r ? ram_q : '0;
  assign lo_mask  = (row_r == first_row) ?
                    ({pfa_pkg::RowW{1'b1}} << reserved_r[pfa_pkg::BitIdxW-1:0]) :
                    {pfa_pkg::RowW{1'b1}};
  assign hi_shift = pfa_pkg::BitIdxW'(pfa_pkg::RowW - 1) - last_pg[pfa_pkg::BitIdxW-1:0];
  assign hi_mask  = (row_r == last_row) ? ({pfa_pkg::RowW{1'b1}} >> hi_shift) :
                                          {pfa_pkg::RowW{1'b1}};
  assign free_bits = ~word & lo_mask & hi_mask;

  always_comb begin
    pick = '0;
    for (int i = pfa_pkg::RowW - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pick = pfa_pkg::BitIdxW'(i);
      end
    end
  end

  assign sel_bit    = mode_r ? rel_bit : pick;
  assign sel_onehot = {{(pfa_pkg::RowW-1){1'b0}}, 1'b1} << sel_bit;
  assign wr_word    = mode_r ? (word & ~sel_onehot) : (word | sel_onehot);

  always_comb begin
    sts              = '0;
    sts.is_alloc     = ~mode_r;
    sts.early        = mode_r ? rel_bad : empty;
    sts.early_status = mode_r ? pfa_pkg::ST_BAD_ADDR : pfa_pkg::ST_OOM;
    sts.hit          = mode_r ? word[rel_bit] : (free_bits != '0);
    sts.last_row     = row_r == last_row;
  end

  pfa_ram #(
    .W (pfa_pkg::RowW),
    .D (pfa_pkg::NumRows)
  ) u_marks (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (row_r),
    .wdata (wr_word),
    .re    (cmd.rd),
    .raddr (row_r),
    .rdata (ram_q)
  );

  // Configuration writes and the free counter.
  always_comb begin
    reserved_nxt = reserved_r;
    total_nxt    = total_r;
    cfg_hit      = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::REG_RESERVED: begin
          reserved_nxt = cfg_data;
          cfg_hit      = 1'b1;
        end
        pfa_pkg::REG_TOTAL: begin
          total_nxt = cfg_data;
          cfg_hit   = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
    free_nxt    = free_r;
    row_vld_nxt = row_vld_r;
    if (cfg_hit) begin
      free_nxt    = pfa_pkg::free_init(reserved_nxt, total_nxt);
      row_vld_nxt = '0;
    end else if (cmd.commit) begin
      row_vld_nxt[row_r] = 1'b1;
      if (mode_r) begin
        free_nxt = (free_r != pfa_pkg::FreeMax) ? free_r + pfa_pkg::PageW'(1) : free_r;
      end else begin
        free_nxt = (free_r != '0) ? free_r - pfa_pkg::PageW'(1) : free_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= pfa_pkg::ReservedReset;
      total_r    <= pfa_pkg::TotalReset;
      free_r     <= pfa_pkg::free_init(pfa_pkg::ReservedReset, pfa_pkg::TotalReset);
      row_vld_r  <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      reserved_r <= reserved_nxt;
      total_r    <= total_nxt;
      free_r     <= free_nxt;
      row_vld_r  <= row_vld_nxt;
      if (cmd.rd) begin
        rd_vld_r <= row_vld_r[row_r];
      end
    end
  end

  // Request capture, scan row and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      addr_r <= in_page_address;
      row_r  <= in_mode ?
                in_page_address[pfa_pkg::OffsW+pfa_pkg::PageIdxW-1:
                                pfa_pkg::OffsW+pfa_pkg::BitIdxW] :
                first_row;
    end else if (cmd.step) begin
      row_r <= row_r + pfa_pkg::RowIdxW'(1);
    end
    if (cmd.commit) begin
      res_status_r <= pfa_pkg::ST_OK;
      res_grant_r  <= mode_r ? '0 : {row_r, pick, {pfa_pkg::OffsW{1'b0}}};
    end else if (cmd.set_status) begin
      res_status_r <= cmd.status;
      res_grant_r  <= '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
      out_free_r   <= free_r;
    end
  end

  assign out_status          = out_status_r;
  assign out_granted_address = out_grant_r;
  assign out_free_count      = out_free_r;

endmodule

FILE: hdl/page_frame_allocator.sv
// Top level of the first-fit page frame allocator.
//
// Requests arrive on in_chan: mode 0 allocates the lowest free page above the
// reserved region, mode 1 releases the page at page_address. Every request
// yields exactly one result beat on out_chan with a status, the granted byte
// address and the free page count after the request.
// The use marks live in a 64 x 64-bit RAM, one bit per page. Each scanned row
// takes a RAM read, then a priority encode of the masked row; an allocation
// scans row by row from the first unreserved row, across up to all 64 rows.
// A release reads and checks one row, and a request rejected up front skips
// the read. One request is in work at a time, and the next one is taken in
// the cycle its predecessor's result shows. The output register holds a
// result until out_chan.ready takes it; the next request is accepted meanwhile,
// and a stalled receiver only holds the block once that request is finished.
// cfg_chan writes reserved_pages (index 0) or page_total (index 1). The user
// must write it only while the block is idle; the block does not enforce this.
// It is always ready. Any such write, and reset, clears all marks at once
// through per-row valid bits and reloads the free counter, so there is no
// clearing pass. Reset leaves 256 reserved pages of 4096.
module page_frame_allocator (
  input logic      clk,
  input logic      rst_n,
  pfa_in_if.sink   in_chan,
  pfa_out_if.source out_chan,
  pfa_cfg_if.sink  cfg_chan
);

  pfa_pkg::cmd_t cmd;
  pfa_pkg::sts_t sts;

  assign cfg_chan.ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfa_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_chan.mode),
    .in_page_address     (in_chan.page_address),
    .cfg_we              (cfg_chan.valid),
    .cfg_index           (cfg_chan.index),
    .cfg_data            (cfg_chan.data),
    .out_status          (out_chan.status),
    .out_granted_address (out_chan.granted_address),
    .out_free_count      (out_chan.free_count)
  );

endmodule
